// ===== design/zcd_pkg.sv =====
// ----------------------------------------------------------------------------
// zcd_pkg
// Shared constants, command struct and key-schedule functions for the
// traditional ZIP stream decryptor.
// ----------------------------------------------------------------------------
package zcd_pkg;

    localparam logic [1:0]  MODE_RESET   = 2'd0;
    localparam logic [1:0]  MODE_ABSORB  = 2'd1;
    localparam logic [1:0]  MODE_DECRYPT = 2'd2;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] KEY0_START   = 32'h1234_5678;
    localparam logic [31:0] KEY1_START   = 32'h2345_6789;
    localparam logic [31:0] KEY2_START   = 32'h3456_7890;
    localparam logic [31:0] KEY1_MULT    = 32'h0808_8405;

    typedef struct packed {
        logic ld_start;
        logic step1;
        logic use_plain;
        logic step2;
        logic out_load;
    } t_cmd;

    function automatic logic [31:0] crc_byte_step(input logic [31:0] crc,
                                                  input logic [7:0]  b);
        logic [31:0] x;
        x = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic [7:0] stream_byte(input logic [31:0] key2);
        logic [15:0] t;
        logic [31:0] p;
        t = key2[15:0] | 16'd2;
        p = {16'd0, t} * {16'd0, t ^ 16'd1};
        return p[15:8];
    endfunction

endpackage

// ===== design/zcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// zcd_ctrl
// Sequencer: takes an item, runs the two key-update steps and manages the
// output register's valid flag.
// ----------------------------------------------------------------------------
module zcd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_mode,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output zcd_pkg::t_cmd o_cmd
);
    import zcd_pkg::*;

    typedef enum logic [0:0] {S_IDLE, S_MIX} t_state;

    t_state r_state;
    logic   r_dec;
    logic   r_out_valid;
    logic   accept;
    logic   finish;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign finish = (r_state == S_MIX) && !(r_dec && r_out_valid && i_out_stall);

    always_comb begin
        o_cmd.ld_start  = accept && (i_mode == MODE_RESET);
        o_cmd.step1     = accept && ((i_mode == MODE_ABSORB) || (i_mode == MODE_DECRYPT));
        o_cmd.use_plain = (i_mode == MODE_DECRYPT);
        o_cmd.step2     = finish;
        o_cmd.out_load  = finish && r_dec;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dec       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.step1) begin
                        r_state <= S_MIX;
                        r_dec   <= o_cmd.use_plain;
                    end
                end
                S_MIX: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !(r_out_valid && i_out_stall))
        else $error("output register overwritten while stalled");

    a_step_to_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step1 |=> (r_state == S_MIX))
        else $error("key update not started after accept");

    a_valid_from_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_dec && r_state == S_MIX))
        else $error("result raised without a decrypt item");

    a_stalled_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("result dropped while stalled");

endmodule

// ===== design/zcd_datapath.sv =====
// ----------------------------------------------------------------------------
// zcd_datapath
// Key registers, keystream, CRC and multiply steps, and the output register.
// ----------------------------------------------------------------------------
module zcd_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  zcd_pkg::t_cmd i_cmd,
    input  logic [7:0]    i_data_byte,
    output logic [7:0]    o_plain_byte
);
    import zcd_pkg::*;

    logic [31:0] r_key0;
    logic [31:0] r_key1;
    logic [31:0] r_key2;
    logic [31:0] r_sum;
    logic [7:0]  r_plain;
    logic [7:0]  r_out;

    logic [7:0]  plain;
    logic [7:0]  feed;
    logic [31:0] n_key0;
    logic [31:0] n_key1;
    logic [31:0] n_key2;

    always_comb begin
        plain  = i_data_byte ^ stream_byte(r_key2);
        feed   = i_cmd.use_plain ? plain : i_data_byte;
        n_key0 = crc_byte_step(r_key0, feed);
        n_key1 = r_sum * KEY1_MULT + 32'd1;
        n_key2 = crc_byte_step(r_key2, n_key1[31:24]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= KEY0_START;
            r_key1 <= KEY1_START;
            r_key2 <= KEY2_START;
        end else if (i_cmd.ld_start) begin
            r_key0 <= KEY0_START;
            r_key1 <= KEY1_START;
            r_key2 <= KEY2_START;
        end else begin
            if (i_cmd.step1) begin
                r_key0 <= n_key0;
            end
            if (i_cmd.step2) begin
                r_key1 <= n_key1;
                r_key2 <= n_key2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step1) begin
            r_sum   <= r_key1 + {24'd0, n_key0[7:0]};
            r_plain <= plain;
        end
        if (i_cmd.out_load) begin
            r_out <= r_plain;
        end
    end

    assign o_plain_byte = r_out;

endmodule

// ===== design/zipcrypto_stream_decrypt.sv =====
// ----------------------------------------------------------------------------
// zipcrypto_stream_decrypt
// Traditional ZIP encryption key schedule and stream decryptor.
// ----------------------------------------------------------------------------
// An absorb or decrypt item runs as a first and a second step: the first forms the keystream
// byte, the plain byte, the key0 CRC step and key1 plus key0's low byte; the
// second does the key1 multiply and the key2 CRC step. A reset item loads the
// start keys when it is taken. A decrypt result sits in an output register, so the next item is
// taken while it waits; the second step of a following decrypt item holds
// only while that register is still full and stalled. Other mode codes are
// consumed with no effect.
module zipcrypto_stream_decrypt (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_plain_byte
);
    import zcd_pkg::*;

    t_cmd cmd;

    zcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_mode      (i_mode),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .o_cmd       (cmd)
    );

    zcd_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_data_byte  (i_data_byte),
        .o_plain_byte (o_plain_byte)
    );

endmodule
